### rtl/acc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the accumulator CPU core: item structs,
// core state record, request kinds, phase codes and opcodes. No dependencies.
package acc_pkg;

  localparam int ADDR_BITS  = 11;
  localparam int WDATA_BITS = 20;
  localparam int TMR_BITS   = 20;
  localparam int CNT_BITS   = 21;
  localparam int MAX_RES    = 4;

  localparam logic [31:0] SYS_CALL_VEC  = 32'd1500;
  localparam logic [31:0] TIMER_VEC     = 32'd1000;
  localparam logic [31:0] USER_TOP      = 32'd999;
  localparam logic [31:0] SYS_STACK_TOP = 32'd1999;
  localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_RESP  = 1'b1;

  localparam logic [2:0] RQ_READ      = 3'd0;
  localparam logic [2:0] RQ_WRITE     = 3'd1;
  localparam logic [2:0] RQ_PORT_INT  = 3'd2;
  localparam logic [2:0] RQ_PORT_CHAR = 3'd3;
  localparam logic [2:0] RQ_HALT      = 3'd4;
  localparam logic [2:0] RQ_FAULT     = 3'd5;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_FETCH   = 4'd1;
  localparam logic [3:0] PH_OPERAND = 4'd2;
  localparam logic [3:0] PH_DEREF   = 4'd3;
  localparam logic [3:0] PH_LOAD_AC = 4'd4;
  localparam logic [3:0] PH_RET     = 4'd5;
  localparam logic [3:0] PH_POP     = 4'd6;
  localparam logic [3:0] PH_IRET_PC = 4'd7;
  localparam logic [3:0] PH_IRET_SP = 4'd8;

  localparam logic [5:0] OP_LOAD_VAL    = 6'd1;
  localparam logic [5:0] OP_LOAD_ADDR   = 6'd2;
  localparam logic [5:0] OP_LOAD_IND    = 6'd3;
  localparam logic [5:0] OP_LOAD_IDX_X  = 6'd4;
  localparam logic [5:0] OP_LOAD_IDX_Y  = 6'd5;
  localparam logic [5:0] OP_LOAD_SP_X   = 6'd6;
  localparam logic [5:0] OP_STORE       = 6'd7;
  localparam logic [5:0] OP_GET         = 6'd8;
  localparam logic [5:0] OP_PUT         = 6'd9;
  localparam logic [5:0] OP_ADD_X       = 6'd10;
  localparam logic [5:0] OP_ADD_Y       = 6'd11;
  localparam logic [5:0] OP_SUB_X       = 6'd12;
  localparam logic [5:0] OP_SUB_Y       = 6'd13;
  localparam logic [5:0] OP_COPY_TO_X   = 6'd14;
  localparam logic [5:0] OP_COPY_FROM_X = 6'd15;
  localparam logic [5:0] OP_COPY_TO_Y   = 6'd16;
  localparam logic [5:0] OP_COPY_FROM_Y = 6'd17;
  localparam logic [5:0] OP_COPY_TO_SP  = 6'd18;
  localparam logic [5:0] OP_COPY_FROM_SP = 6'd19;
  localparam logic [5:0] OP_JUMP        = 6'd20;
  localparam logic [5:0] OP_JUMP_EQ     = 6'd21;
  localparam logic [5:0] OP_JUMP_NE     = 6'd22;
  localparam logic [5:0] OP_CALL        = 6'd23;
  localparam logic [5:0] OP_RET         = 6'd24;
  localparam logic [5:0] OP_INC_X       = 6'd25;
  localparam logic [5:0] OP_DEC_X       = 6'd26;
  localparam logic [5:0] OP_PUSH        = 6'd27;
  localparam logic [5:0] OP_POP         = 6'd28;
  localparam logic [5:0] OP_INT         = 6'd29;
  localparam logic [5:0] OP_IRET        = 6'd30;
  localparam logic [5:0] OP_END         = 6'd50;

  localparam logic [5:0] PORT_SEL_INT = 6'd1;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] read_data;
    logic [6:0]        random_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            request_kind;
    logic [ADDR_BITS-1:0]  address;
    logic [WDATA_BITS-1:0] write_data;
    logic signed [31:0]    port_value;
    logic                  violation;
    logic                  last;
  } out_item_t;

  typedef out_item_t [MAX_RES-1:0] res_vec_t;

  typedef struct packed {
    logic [31:0]         pc;
    logic [31:0]         sp;
    logic [5:0]          ir;
    logic [31:0]         ac;
    logic [31:0]         ix;
    logic [31:0]         iy;
    logic                sys;
    logic [3:0]          phase;
    logic [CNT_BITS-1:0] ucnt;
    logic                halted;
  } core_state_t;

endpackage

### rtl/acc_exec.sv
`timescale 1ns / 1ps
// Execution step of the accumulator CPU: next core state and up to four bus
// results for one item. Depends on acc_pkg.
module acc_exec import acc_pkg::*; (
  input  core_state_t         st_i,
  input  in_item_t            item_i,
  input  logic [TMR_BITS-1:0] tmr_i,
  output core_state_t         st_o,
  output res_vec_t            res_o,
  output logic [2:0]          cnt_o
);

  function automatic out_item_t mk_res(logic [2:0] kind, logic [31:0] addr,
                                       logic [31:0] wdata, logic [31:0] port,
                                       logic viol);
    out_item_t r;
    r.request_kind = kind;
    r.address      = addr[ADDR_BITS-1:0];
    r.write_data   = wdata[WDATA_BITS-1:0];
    r.port_value   = port;
    r.violation    = viol;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic violates(logic [31:0] a, logic sys);
    return !sys && !a[31] && (a > USER_TOP);
  endfunction

  core_state_t s;
  res_vec_t    r;
  logic [2:0]  n;
  logic [31:0] v;
  logic        fin;
  logic        op_ok;
  logic [2:0]  lst;

  always_comb begin
    s     = st_i;
    r     = '0;
    n     = 3'd0;
    fin   = 1'b0;
    v     = item_i.read_data;
    lst   = 3'd0;
    op_ok = (v[31:6] == 26'd0) &&
            (((v[5:0] >= OP_LOAD_VAL) && (v[5:0] <= OP_IRET)) || (v[5:0] == OP_END));

    if (!s.halted) begin
      if (s.phase == PH_IDLE) begin
        if (item_i.kind == KIND_START) begin
          if (v != 32'd0) begin
            r[n[1:0]] = mk_res(RQ_HALT, 32'd0, 32'd0, 32'd0, 1'b0);
            n = n + 3'd1;
            s.halted = 1'b1;
            s.phase = PH_IDLE;
          end else begin
            s.ucnt = '0;
            r[n[1:0]] = mk_res(RQ_READ, s.pc, 32'd0, 32'd0, violates(s.pc, s.sys));
            n = n + 3'd1;
            s.pc = s.pc + 32'd1;
            s.phase = PH_FETCH;
          end
        end
      end else if (item_i.kind == KIND_RESP) begin
        case (s.phase)
          PH_FETCH: begin
            s.ir = v[5:0];
            if (!op_ok) begin
              r[n[1:0]] = mk_res(RQ_FAULT, 32'd0, 32'd0, 32'd0, 1'b0);
              n = n + 3'd1;
              s.halted = 1'b1;
              s.phase = PH_IDLE;
            end else begin
              case (v[5:0])
                OP_LOAD_VAL, OP_LOAD_ADDR, OP_LOAD_IND, OP_LOAD_IDX_X, OP_LOAD_IDX_Y,
                OP_STORE, OP_PUT, OP_JUMP, OP_JUMP_EQ, OP_JUMP_NE, OP_CALL: begin
                  r[n[1:0]] = mk_res(RQ_READ, s.pc, 32'd0, 32'd0, violates(s.pc, s.sys));
                  n = n + 3'd1;
                  s.pc = s.pc + 32'd1;
                  s.phase = PH_OPERAND;
                end
                OP_LOAD_SP_X: begin
                  r[n[1:0]] = mk_res(RQ_READ, s.sp + s.ix, 32'd0, 32'd0,
                                     violates(s.sp + s.ix, s.sys));
                  n = n + 3'd1;
                  s.phase = PH_LOAD_AC;
                end
                OP_GET: begin
                  s.ac = {25'd0, item_i.random_value};
                  fin = 1'b1;
                end
                OP_ADD_X:        begin s.ac = s.ac + s.ix; fin = 1'b1; end
                OP_ADD_Y:        begin s.ac = s.ac + s.iy; fin = 1'b1; end
                OP_SUB_X:        begin s.ac = s.ac - s.ix; fin = 1'b1; end
                OP_SUB_Y:        begin s.ac = s.ac - s.iy; fin = 1'b1; end
                OP_COPY_TO_X:    begin s.ix = s.ac; fin = 1'b1; end
                OP_COPY_FROM_X:  begin s.ac = s.ix; fin = 1'b1; end
                OP_COPY_TO_Y:    begin s.iy = s.ac; fin = 1'b1; end
                OP_COPY_FROM_Y:  begin s.ac = s.iy; fin = 1'b1; end
                OP_COPY_TO_SP:   begin s.sp = s.ac; fin = 1'b1; end
                OP_COPY_FROM_SP: begin s.ac = s.sp; fin = 1'b1; end
                OP_INC_X:        begin s.ix = s.ix + 32'd1; fin = 1'b1; end
                OP_DEC_X:        begin s.ix = s.ix - 32'd1; fin = 1'b1; end
                OP_RET, OP_POP, OP_IRET: begin
                  r[n[1:0]] = mk_res(RQ_READ, s.sp, 32'd0, 32'd0, violates(s.sp, s.sys));
                  n = n + 3'd1;
                  if (v[5:0] == OP_RET) begin
                    s.phase = PH_RET;
                  end else if (v[5:0] == OP_POP) begin
                    s.phase = PH_POP;
                  end else begin
                    s.phase = PH_IRET_PC;
                  end
                end
                OP_PUSH: begin
                  s.sp = s.sp - 32'd1;
                  r[n[1:0]] = mk_res(RQ_WRITE, s.sp, s.ac, 32'd0, violates(s.sp, s.sys));
                  n = n + 3'd1;
                  fin = 1'b1;
                end
                OP_INT: begin
                  if (!s.sys) begin
                    s.sys = 1'b1;
                    r[n[1:0]] = mk_res(RQ_WRITE, SYS_STACK_TOP - 32'd1, s.sp, 32'd0, 1'b0);
                    n = n + 3'd1;
                    s.sp = SYS_STACK_TOP - 32'd2;
                    r[n[1:0]] = mk_res(RQ_WRITE, s.sp, s.pc, 32'd0, 1'b0);
                    n = n + 3'd1;
                    s.pc = SYS_CALL_VEC;
                  end
                  fin = 1'b1;
                end
                default: begin
                  r[n[1:0]] = mk_res(RQ_HALT, 32'd0, 32'd0, 32'd0, 1'b0);
                  n = n + 3'd1;
                  s.halted = 1'b1;
                  s.phase = PH_IDLE;
                end
              endcase
            end
          end
          PH_OPERAND: begin
            fin = 1'b1;
            case (s.ir)
              OP_LOAD_VAL: s.ac = v;
              OP_LOAD_ADDR, OP_LOAD_IND: begin
                r[n[1:0]] = mk_res(RQ_READ, v, 32'd0, 32'd0, violates(v, s.sys));
                n = n + 3'd1;
                s.phase = (s.ir == OP_LOAD_IND) ? PH_DEREF : PH_LOAD_AC;
                fin = 1'b0;
              end
              OP_LOAD_IDX_X: begin
                r[n[1:0]] = mk_res(RQ_READ, v + s.ix, 32'd0, 32'd0, violates(v + s.ix, s.sys));
                n = n + 3'd1;
                s.phase = PH_LOAD_AC;
                fin = 1'b0;
              end
              OP_LOAD_IDX_Y: begin
                r[n[1:0]] = mk_res(RQ_READ, v + s.iy, 32'd0, 32'd0, violates(v + s.iy, s.sys));
                n = n + 3'd1;
                s.phase = PH_LOAD_AC;
                fin = 1'b0;
              end
              OP_STORE: begin
                r[n[1:0]] = mk_res(RQ_WRITE, v, s.ac, 32'd0, violates(v, s.sys));
                n = n + 3'd1;
              end
              OP_PUT: begin
                r[n[1:0]] = mk_res((v == {26'd0, PORT_SEL_INT}) ? RQ_PORT_INT : RQ_PORT_CHAR,
                                   32'd0, 32'd0, s.ac, 1'b0);
                n = n + 3'd1;
              end
              OP_JUMP: s.pc = v;
              OP_JUMP_EQ: begin
                if (s.ac == 32'd0) begin
                  s.pc = v;
                end
              end
              OP_JUMP_NE: begin
                if (s.ac != 32'd0) begin
                  s.pc = v;
                end
              end
              OP_CALL: begin
                s.sp = s.sp - 32'd1;
                r[n[1:0]] = mk_res(RQ_WRITE, s.sp, s.pc, 32'd0, violates(s.sp, s.sys));
                n = n + 3'd1;
                s.pc = v;
              end
              default: ;
            endcase
          end
          PH_DEREF: begin
            r[n[1:0]] = mk_res(RQ_READ, v, 32'd0, 32'd0, violates(v, s.sys));
            n = n + 3'd1;
            s.phase = PH_LOAD_AC;
          end
          PH_LOAD_AC: begin
            s.ac = v;
            fin = 1'b1;
          end
          PH_RET: begin
            s.pc = v;
            s.sp = s.sp + 32'd1;
            fin = 1'b1;
          end
          PH_POP: begin
            s.ac = v;
            s.sp = s.sp + 32'd1;
            fin = 1'b1;
          end
          PH_IRET_PC: begin
            s.pc = v;
            s.sp = s.sp + 32'd1;
            r[n[1:0]] = mk_res(RQ_READ, s.sp, 32'd0, 32'd0, violates(s.sp, s.sys));
            n = n + 3'd1;
            s.phase = PH_IRET_SP;
          end
          PH_IRET_SP: begin
            s.sp = v;
            s.sys = 1'b0;
            fin = 1'b1;
          end
          default: s.phase = PH_IDLE;
        endcase
      end
    end

    // instruction retire: user count, timer trap, next fetch
    if (fin) begin
      if (!s.sys && (s.ucnt != COUNT_MAX)) begin
        s.ucnt = s.ucnt + 1'b1;
      end
      if ((tmr_i > 20'd1) && (s.ucnt >= {1'b0, tmr_i})) begin
        if (!s.sys) begin
          s.sys = 1'b1;
          r[n[1:0]] = mk_res(RQ_WRITE, SYS_STACK_TOP - 32'd1, s.sp, 32'd0, 1'b0);
          n = n + 3'd1;
          s.sp = SYS_STACK_TOP - 32'd2;
          r[n[1:0]] = mk_res(RQ_WRITE, s.sp, s.pc, 32'd0, 1'b0);
          n = n + 3'd1;
          s.pc = TIMER_VEC;
        end
        s.ucnt = '0;
      end
      r[n[1:0]] = mk_res(RQ_READ, s.pc, 32'd0, 32'd0, violates(s.pc, s.sys));
      n = n + 3'd1;
      s.pc = s.pc + 32'd1;
      s.phase = PH_FETCH;
    end

    if (n != 3'd0) begin
      lst = n - 3'd1;
      r[lst[1:0]].last = 1'b1;
    end

    st_o  = s;
    res_o = r;
    cnt_o = n;
  end

endmodule

### rtl/accumulator_cpu_core.sv
`timescale 1ns / 1ps
// Top level of the accumulator CPU core: input register, core state, result
// buffer and timer interval register. Depends on acc_pkg and acc_exec.

// An item (start or memory read response) is registered on acceptance and
// executed once the result buffer is free or hands out its last entry, which
// loads all of its results (zero to four bus requests, port outputs, halt or
// fault) into a four-entry result buffer. The buffer presents one result item
// per cycle while the output side does not stall, and an item that causes N
// results holds the buffer until all N are taken; a new item is accepted every
// cycle while each item causes at most one result and the output side does not
// stall. The timer interval register may be written at any time (cfg_ready_o is
// always high) but is meant to change only while the core is idle.
module accumulator_cpu_core import acc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TMR_BITS-1:0] cfg_data_i
);

  logic                in_vld_q;
  in_item_t            in_q;
  core_state_t         st_q;
  core_state_t         st_d;
  res_vec_t            res_q;
  res_vec_t            res_d;
  logic [2:0]          cnt_d;
  logic [2:0]          rem_q;
  logic [1:0]          idx_q;
  logic [TMR_BITS-1:0] tmr_q;
  logic                out_take;
  logic                buf_free;
  logic                go;
  logic                in_take;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (rem_q != 3'd0);
  assign out_item_o  = res_q[idx_q];
  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free    = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_take);
  assign go          = in_vld_q && buf_free;
  assign in_stall_o  = in_vld_q && !go;
  assign in_take     = in_valid_i && !in_stall_o;

  acc_exec u_exec (
    .st_i   (st_q),
    .item_i (in_q),
    .tmr_i  (tmr_q),
    .st_o   (st_d),
    .res_o  (res_d),
    .cnt_o  (cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      rem_q    <= 3'd0;
      idx_q    <= 2'd0;
      tmr_q    <= '0;
      st_q     <= '{pc: 32'd0, sp: USER_TOP, ir: 6'd0, ac: 32'd0, ix: 32'd0,
                    iy: 32'd0, sys: 1'b0, phase: PH_IDLE, ucnt: '0, halted: 1'b0};
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        tmr_q <= cfg_data_i;
      end
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (go) begin
        in_vld_q <= 1'b0;
      end
      if (go) begin
        st_q  <= st_d;
        rem_q <= cnt_d;
        idx_q <= 2'd0;
      end else if (out_take) begin
        rem_q <= rem_q - 3'd1;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (go) begin
      res_q <= res_d;
    end
  end

endmodule

### sim/accumulator_cpu_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for accumulator_cpu_core: runs one program through the
// core, predicting every bus request, port output and halt. Depends on acc_pkg.
module accumulator_cpu_core_test;
  import acc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 10;
  localparam int PHASE_ITEMS = 16;
  localparam int HOLD_CYCLES = 60;

  class request_board;
    logic [TMR_BITS-1:0] interval = '0;
    logic [31:0]         pc = '0, sp = USER_TOP, ac = '0, ix = '0, iy = '0;
    logic [5:0]          ir = '0;
    logic                sys = 1'b0, halted = 1'b0;
    logic [3:0]          phase = PH_IDLE;
    logic [CNT_BITS-1:0] ucnt = '0;
    out_item_t           batch[$];
    out_item_t           due[$];
    int                  errors = 0;

    function logic violates(logic [31:0] a);
      return !sys && !a[31] && (a > USER_TOP);
    endfunction

    function void post(logic [2:0] k, logic [31:0] a, logic [31:0] d, logic [31:0] pv,
                       logic vi);
      out_item_t r;
      if (batch.size() >= MAX_RES) return;
      r = '0;
      r.request_kind = k;
      r.address      = a[ADDR_BITS-1:0];
      r.write_data   = d[WDATA_BITS-1:0];
      r.port_value   = pv;
      r.violation    = vi;
      batch.push_back(r);
    endfunction

    function void read_bus(logic [31:0] a);
      post(RQ_READ, a, '0, '0, violates(a));
    endfunction

    function void write_bus(logic [31:0] a, logic [31:0] d);
      post(RQ_WRITE, a, d, '0, violates(a));
    endfunction

    function void fetch_next(logic [3:0] ph);
      read_bus(pc);
      pc    = pc + 1;
      phase = ph;
    endfunction

    function void enter_sys(logic [31:0] vec);
      sys = 1'b1;
      write_bus(SYS_STACK_TOP - 1, sp);
      sp = SYS_STACK_TOP - 2;
      write_bus(sp, pc);
      pc = vec;
    endfunction

    function void retire();
      if (!sys && ucnt < COUNT_MAX) ucnt = ucnt + 1'b1;
      if (interval > 1 && ucnt >= interval) begin
        if (!sys) enter_sys(TIMER_VEC);
        ucnt = '0;
      end
      fetch_next(PH_FETCH);
    endfunction

    function void halt_core(logic [2:0] k);
      post(k, '0, '0, '0, 1'b0);
      halted = 1'b1;
      phase  = PH_IDLE;
    endfunction

    function void decode(logic [31:0] v, logic [6:0] rnd);
      ir = v[5:0];
      if (!((v >= OP_LOAD_VAL && v <= OP_IRET) || v == OP_END)) begin
        halt_core(RQ_FAULT);
        return;
      end
      case (ir)
        OP_LOAD_VAL, OP_LOAD_ADDR, OP_LOAD_IND, OP_LOAD_IDX_X, OP_LOAD_IDX_Y, OP_STORE,
        OP_PUT, OP_JUMP, OP_JUMP_EQ, OP_JUMP_NE, OP_CALL: begin
          fetch_next(PH_OPERAND);
          return;
        end
        OP_LOAD_SP_X: begin
          read_bus(sp + ix);
          phase = PH_LOAD_AC;
          return;
        end
        OP_GET:          ac = {25'b0, rnd};
        OP_ADD_X:        ac = ac + ix;
        OP_ADD_Y:        ac = ac + iy;
        OP_SUB_X:        ac = ac - ix;
        OP_SUB_Y:        ac = ac - iy;
        OP_COPY_TO_X:    ix = ac;
        OP_COPY_FROM_X:  ac = ix;
        OP_COPY_TO_Y:    iy = ac;
        OP_COPY_FROM_Y:  ac = iy;
        OP_COPY_TO_SP:   sp = ac;
        OP_COPY_FROM_SP: ac = sp;
        OP_RET: begin
          read_bus(sp);
          phase = PH_RET;
          return;
        end
        OP_INC_X:        ix = ix + 1;
        OP_DEC_X:        ix = ix - 1;
        OP_PUSH: begin
          sp = sp - 1;
          write_bus(sp, ac);
        end
        OP_POP: begin
          read_bus(sp);
          phase = PH_POP;
          return;
        end
        OP_INT:          if (!sys) enter_sys(SYS_CALL_VEC);
        OP_IRET: begin
          read_bus(sp);
          phase = PH_IRET_PC;
          return;
        end
        default: begin
          halt_core(RQ_HALT);
          return;
        end
      endcase
      retire();
    endfunction

    function void use_operand(logic [31:0] a);
      case (ir)
        OP_LOAD_VAL: ac = a;
        OP_LOAD_ADDR: begin
          read_bus(a);
          phase = PH_LOAD_AC;
          return;
        end
        OP_LOAD_IND: begin
          read_bus(a);
          phase = PH_DEREF;
          return;
        end
        OP_LOAD_IDX_X: begin
          read_bus(a + ix);
          phase = PH_LOAD_AC;
          return;
        end
        OP_LOAD_IDX_Y: begin
          read_bus(a + iy);
          phase = PH_LOAD_AC;
          return;
        end
        OP_STORE:   write_bus(a, ac);
        OP_PUT:     post((a == {26'b0, PORT_SEL_INT}) ? RQ_PORT_INT : RQ_PORT_CHAR,
                         '0, '0, ac, 1'b0);
        OP_JUMP:    pc = a;
        OP_JUMP_EQ: if (ac == 0) pc = a;
        OP_JUMP_NE: if (ac != 0) pc = a;
        OP_CALL: begin
          sp = sp - 1;
          write_bus(sp, pc);
          pc = a;
        end
        default: ;
      endcase
      retire();
    endfunction

    function void take_item(in_item_t it);
      logic [31:0] v;
      out_item_t   r;
      v = it.read_data;
      batch.delete();
      if (!halted) begin
        if (phase == PH_IDLE) begin
          if (it.kind == KIND_START) begin
            if (v != 0) halt_core(RQ_HALT);
            else begin
              ucnt = '0;
              fetch_next(PH_FETCH);
            end
          end
        end else if (it.kind == KIND_RESP) begin
          case (phase)
            PH_FETCH:   decode(v, it.random_value);
            PH_OPERAND: use_operand(v);
            PH_DEREF: begin
              read_bus(v);
              phase = PH_LOAD_AC;
            end
            PH_LOAD_AC: begin
              ac = v;
              retire();
            end
            PH_RET: begin
              pc = v;
              sp = sp + 1;
              retire();
            end
            PH_POP: begin
              ac = v;
              sp = sp + 1;
              retire();
            end
            PH_IRET_PC: begin
              pc = v;
              sp = sp + 1;
              read_bus(sp);
              phase = PH_IRET_SP;
            end
            PH_IRET_SP: begin
              sp  = v;
              sys = 1'b0;
              retire();
            end
            default: phase = PH_IDLE;
          endcase
        end
      end
      foreach (batch[i]) begin
        r      = batch[i];
        r.last = (i == batch.size() - 1);
        due.push_back(r);
      end
    endfunction

    function void match_request(out_item_t got);
      out_item_t exp;
      if (due.size() == 0) begin
        $error("unexpected result item, request_kind %0d", got.request_kind);
        errors++;
        return;
      end
      exp = due.pop_front();
      if (got.request_kind !== exp.request_kind) begin
        $error("request_kind: expected %0d, actual %0d", exp.request_kind, got.request_kind);
        errors++;
      end
      if (got.address !== exp.address) begin
        $error("address: expected %0d, actual %0d", exp.address, got.address);
        errors++;
      end
      if (got.write_data !== exp.write_data) begin
        $error("write_data: expected %0h, actual %0h", exp.write_data, got.write_data);
        errors++;
      end
      if (got.port_value !== exp.port_value) begin
        $error("port_value: expected %0d, actual %0d", exp.port_value, got.port_value);
        errors++;
      end
      if (got.violation !== exp.violation) begin
        $error("violation: expected %0b, actual %0b", exp.violation, got.violation);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, actual %0b", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item    = '0;
  logic                out_valid_o;
  logic                out_stall  = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready_o;
  logic [TMR_BITS-1:0] cfg_data   = '0;

  request_board board = new();
  int send_idle_pct = 32;
  int recv_idle_pct = 67;
  int hold_len      = 0;
  int fed           = 0;
  int quiet         = 0;

  accumulator_cpu_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) board.match_request(out_item_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o) || !rst_ni) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0:       return $urandom_range(USER_TOP);
      1:       return $urandom_range(SYS_STACK_TOP, TIMER_VEC);
      2:       return $urandom_range((1 << ADDR_BITS) - 1);
      3:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [5:0] pick_op();
    if (board.sys && $urandom_range(3) == 0) return OP_IRET;
    return 6'($urandom_range(OP_IRET, OP_LOAD_VAL));
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.take_item(it);
  endtask

  task automatic offer(input logic kind, input logic [31:0] data);
    in_item_t it;
    it.kind         = kind;
    it.read_data    = data;
    it.random_value = 7'($urandom_range(100, 1));
    send_item(it);
  endtask

  // Feeds one instruction word, then answers every read the core issues until
  // it asks for the next instruction.
  task automatic run_op(input logic [31:0] word, input logic [31:0] opnd,
                        input logic [6:0] rnd);
    in_item_t it;
    it.kind         = KIND_RESP;
    it.read_data    = word;
    it.random_value = rnd;
    send_item(it);
    fed++;
    while (!board.halted && board.phase != PH_FETCH) begin
      it.read_data    = (board.phase == PH_OPERAND) ? opnd : pick_word();
      it.random_value = 7'($urandom_range(100, 1));
      send_item(it);
      fed++;
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [TMR_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.interval = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [TMR_BITS-1:0] intervals [6];
    logic [31:0]         word;
    logic [5:0]          op;
    int                  mark;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_interval(TMR_BITS'(5));
    offer(KIND_RESP, pick_word());
    offer(KIND_START, '0);
    run_op({26'b0, OP_LOAD_VAL}, 32'h7FFF_FFFF, 7'd1);
    run_op({26'b0, OP_PUT}, {26'b0, PORT_SEL_INT}, 7'd1);
    run_op({26'b0, OP_LOAD_VAL}, 32'h8000_0000, 7'd1);
    run_op({26'b0, OP_PUT}, '0, 7'd1);
    offer(KIND_START, '0);
    run_op({26'b0, OP_GET}, '0, 7'd100);
    run_op({26'b0, OP_COPY_TO_X}, '0, 7'd1);
    run_op({26'b0, OP_STORE}, TIMER_VEC, 7'd1);
    run_op({26'b0, OP_LOAD_SP_X}, '0, 7'd1);
    run_op({26'b0, OP_INT}, '0, 7'd1);
    run_op({26'b0, OP_STORE}, (1 << ADDR_BITS) - 1, 7'd1);
    run_op({26'b0, OP_IRET}, '0, 7'd1);

    intervals = '{TMR_BITS'(3), {TMR_BITS{1'b1}}, TMR_BITS'(2), TMR_BITS'(1),
                  TMR_BITS'($urandom_range(9, 4)), TMR_BITS'(0)};
    for (int p = 0; p < 6; p++) begin
      wait_drain();
      send_idle_pct = (p < 2) ? 32 : (p < 4) ? 67 : 0;
      recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 32 : 0;
      write_interval(intervals[p]);
      if (p == 4) hold_len = HOLD_CYCLES;
      mark = fed;
      while (fed - mark < PHASE_ITEMS) begin
        if ($urandom_range(99) < 8) offer(KIND_START, pick_word());
        op = pick_op();
        run_op({26'b0, op},
               (op == OP_PUT && $urandom_range(1)) ? {26'b0, PORT_SEL_INT} : pick_word(),
               7'($urandom_range(100, 1)));
      end
    end

    // stop the program on an end opcode or an undefined word, then poke the halted core
    case ($urandom_range(3))
      0:       word = {26'b0, OP_END};
      1:       word = '0;
      2:       word = {26'b0, 6'($urandom_range(6'h3F, OP_IRET + 1))};
      default: word = 32'h0100_0000 | {26'b0, OP_LOAD_VAL};
    endcase
    run_op(word, pick_word(), 7'($urandom_range(100, 1)));
    offer(KIND_START, '0);
    offer(KIND_RESP, pick_word());
    wait_drain();

    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/acc_pkg.sv
rtl/acc_exec.sv
rtl/accumulator_cpu_core.sv
sim/accumulator_cpu_core_test.sv
